### src/utp_pkg.sv
package utp_pkg;

	// String lengths of the three accepted forms, and the saturation point.
	localparam logic [5:0] PLAIN_LEN  = 6'd32;
	localparam logic [5:0] DASHED_LEN = 6'd36;
	localparam logic [5:0] BRACED_LEN = 6'd38;
	localparam logic [5:0] COUNT_MAX  = 6'd39;

	// Dash positions within the 36-character dashed form.
	localparam logic [5:0] DASH_POS_0 = 6'd8;
	localparam logic [5:0] DASH_POS_1 = 6'd13;
	localparam logic [5:0] DASH_POS_2 = 6'd18;
	localparam logic [5:0] DASH_POS_3 = 6'd23;

	// Framing characters.
	localparam logic [7:0] OPEN_BRACE  = 8'h7B;
	localparam logic [7:0] CLOSE_BRACE = 8'h7D;
	localparam logic [7:0] DASH_CHAR   = 8'h2D;

	// One input character with its side-band bits.
	typedef struct packed {
		logic [7:0] text_char;
		logic       final_char;
		logic       swap_time;
	} utp_char_t;

	// One parsed UUID.
	typedef struct packed {
		logic [63:0] uuid_high;
		logic [63:0] uuid_low;
		logic        valid_uuid;
	} utp_result_t;

endpackage

### src/utp_char_if.sv
interface utp_char_if import utp_pkg::*; ();

	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       final_char;
	logic       swap_time;

	modport source (output valid, text_char, final_char, swap_time, input ready);
	modport sink (input valid, text_char, final_char, swap_time, output ready);

endinterface

### src/utp_uuid_if.sv
interface utp_uuid_if import utp_pkg::*; ();

	logic        valid;
	logic        ready;
	logic [63:0] uuid_high;
	logic [63:0] uuid_low;
	logic        valid_uuid;

	modport source (output valid, uuid_high, uuid_low, valid_uuid, input ready);
	modport sink (input valid, uuid_high, uuid_low, valid_uuid, output ready);

endinterface

### src/utp_in_stage.sv
module utp_in_stage import utp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	utp_char_if.sink   chars,
	input  logic       advance,
	output logic       valid_s1,
	output utp_char_t  item_s1
);

	logic accept;

	// The stage takes a new character whenever its current one moves on.
	assign chars.ready = !valid_s1 || advance;
	assign accept      = chars.valid && chars.ready;

	// Valid flag of the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	// Payload of the input register.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.text_char  <= chars.text_char;
			item_s1.final_char <= chars.final_char;
			item_s1.swap_time  <= chars.swap_time;
		end
	end

endmodule

### src/utp_scan.sv
module utp_scan import utp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  utp_char_t   item,
	output utp_result_t result
);

	logic [5:0]   char_count_q;
	logic [127:0] acc_q;
	logic         plain_ok_q;
	logic         dashed_ok_q;
	logic         braced_ok_q;

	logic [7:0]   c;
	logic [7:0]   lc;
	logic         is_hex;
	logic [3:0]   nib;
	logic [5:0]   p;
	logic [5:0]   p_prev;
	logic [5:0]   count_d;
	logic [127:0] acc_d;
	logic         plain_d;
	logic         dashed_d;
	logic         braced_d;
	logic         ok;
	logic [63:0]  hi;

	// True when byte ch fits position pos of the dashed form.
	function automatic logic dashed_fits(input logic [5:0] pos, input logic [7:0] ch,
			input logic hex);
		logic dash_pos;
		dash_pos = (pos == DASH_POS_0) || (pos == DASH_POS_1) ||
			(pos == DASH_POS_2) || (pos == DASH_POS_3);
		return dash_pos ? (ch == DASH_CHAR) : hex;
	endfunction

	// Hex digit decode, either letter case.
	always_comb begin
		c      = item.text_char;
		lc     = c | 8'h20;
		is_hex = 1'b0;
		nib    = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			is_hex = 1'b1;
			nib    = c[3:0];
		end else if (lc >= 8'h61 && lc <= 8'h66) begin
			is_hex = 1'b1;
			nib    = lc[3:0] + 4'd9;
		end
	end

	// Form checks, accumulator shift and length count.
	always_comb begin
		p        = char_count_q;
		p_prev   = p - 6'd1;
		plain_d  = plain_ok_q;
		dashed_d = dashed_ok_q;
		braced_d = braced_ok_q;
		if (p < PLAIN_LEN && !is_hex) begin
			plain_d = 1'b0;
		end
		if (p < DASHED_LEN && !dashed_fits(p, c, is_hex)) begin
			dashed_d = 1'b0;
		end
		if (p == 6'd0) begin
			if (c != OPEN_BRACE) begin
				braced_d = 1'b0;
			end
		end else if (p <= DASHED_LEN) begin
			if (!dashed_fits(p_prev, c, is_hex)) begin
				braced_d = 1'b0;
			end
		end else if (p == BRACED_LEN - 6'd1) begin
			if (c != CLOSE_BRACE) begin
				braced_d = 1'b0;
			end
		end
		acc_d   = is_hex ? {acc_q[123:0], nib} : acc_q;
		count_d = (p < COUNT_MAX) ? p + 6'd1 : COUNT_MAX;
	end

	// Result assembly, with the optional time field reorder.
	always_comb begin
		ok = (count_d == PLAIN_LEN && plain_d) ||
			(count_d == DASHED_LEN && dashed_d) ||
			(count_d == BRACED_LEN && braced_d);
		hi = acc_d[127:64];
		if (item.swap_time) begin
			hi = {acc_d[79:64], acc_d[95:80], acc_d[127:96]};
		end
		result.uuid_high  = ok ? hi : 64'd0;
		result.uuid_low   = ok ? acc_d[63:0] : 64'd0;
		result.valid_uuid = ok;
	end

	// Parser state; the last character of a string returns it to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= 6'd0;
			acc_q        <= 128'd0;
			plain_ok_q   <= 1'b1;
			dashed_ok_q  <= 1'b1;
			braced_ok_q  <= 1'b1;
		end else if (step) begin
			if (item.final_char) begin
				char_count_q <= 6'd0;
				acc_q        <= 128'd0;
				plain_ok_q   <= 1'b1;
				dashed_ok_q  <= 1'b1;
				braced_ok_q  <= 1'b1;
			end else begin
				char_count_q <= count_d;
				acc_q        <= acc_d;
				plain_ok_q   <= plain_d;
				dashed_ok_q  <= dashed_d;
				braced_ok_q  <= braced_d;
			end
		end
	end

endmodule

### src/utp_out_stage.sv
module utp_out_stage import utp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  utp_result_t result,
	output logic        busy,
	utp_uuid_if.source  uuids
);

	logic        valid_q;
	utp_result_t result_q;

	// A held result blocks a new one only while the receiver stalls.
	assign busy = valid_q && !uuids.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (uuids.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	assign uuids.valid      = valid_q;
	assign uuids.uuid_high  = result_q.uuid_high;
	assign uuids.uuid_low   = result_q.uuid_low;
	assign uuids.valid_uuid = result_q.valid_uuid;

endmodule

### src/uuid_text_parser.sv
// UUID text parser.
// The chars channel carries a UUID string one byte per transfer, with
// final_char set on the last byte and swap_time sampled with that byte.
// The uuids channel returns one transfer per string: the 128-bit value
// in uuid_high and uuid_low and the valid_uuid flag. Accepted forms are
// 32 hex digits, the 36-character dashed form and the 38-character
// braced form; anything else returns zeros with valid_uuid low.
// Throughput is one byte per cycle except while a final byte waits on a
// stalled receiver: each byte passes an input register, the character
// checks and shifts update the parser state, and the final byte's result
// lands in the output register, from which it is offered to the receiver.
// While the receiver stalls, bytes that are not final keep flowing; a
// final byte waits in the input register until the held result is taken.
// Reset clears the input and output valid flags and returns the parser
// to the start of a string.
module uuid_text_parser import utp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	utp_char_if.sink   chars,
	utp_uuid_if.source uuids
);

	logic        valid_s1;
	utp_char_t   item_s1;
	logic        advance;
	logic        step;
	logic        busy;
	utp_result_t result;

	// A final byte may move on only when the output register can take it.
	assign advance = !(item_s1.final_char && busy);
	assign step    = valid_s1 && advance;

	utp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	utp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

	utp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && item_s1.final_char),
		.result (result),
		.busy   (busy),
		.uuids  (uuids)
	);

endmodule

### src/utp_checker.sv
module utp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_final,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_high,
	input logic [63:0] out_low,
	input logic        out_ok
);

	// A result offered to a stalled receiver stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_high) && $stable(out_low) && $stable(out_ok))
		else $error("result payload changed while stalled");

	// An invalid string always reports an all-zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ok |-> out_high == 64'd0 && out_low == 64'd0)
		else $error("invalid result with nonzero value");

	// A result appearing on an idle output must follow an accepted final byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_final, 2))
		else $error("result without a final byte");

endmodule

bind uuid_text_parser utp_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_final  (chars.final_char),
	.out_valid (uuids.valid),
	.out_ready (uuids.ready),
	.out_high  (uuids.uuid_high),
	.out_low   (uuids.uuid_low),
	.out_ok    (uuids.valid_uuid)
);
